// ===== rtl/fpa_pkg.sv =====
// Shared types and constants for the Q24.8 fixed-point ALU.
package fpa_pkg;

    localparam int FRACTION_BITS = 8;
    localparam int WORD_W        = 32;
    localparam int DIV_STEPS     = WORD_W + FRACTION_BITS;
    localparam int FLT_BIAS_SH   = 150 - FRACTION_BITS;
    localparam int EXP_OFFSET    = 127 - FRACTION_BITS;
    localparam int FAST_LAT      = 3;
    localparam int DIV_LAT       = DIV_STEPS + 2;
    localparam int DLY_STAGES    = DIV_LAT - FAST_LAT;

    typedef enum logic [3:0] {
        K_ADD      = 4'd0,
        K_SUB      = 4'd1,
        K_MUL      = 4'd2,
        K_DIV      = 4'd3,
        K_CMP      = 4'd4,
        K_INT2FIX  = 4'd5,
        K_FLT2FIX  = 4'd6,
        K_TO_FLOAT = 4'd7,
        K_TO_INT   = 4'd8
    } t_kind;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [31:0]       flt;
        logic              gt;
        logic              eq;
        logic              lt;
        logic              dz;
        logic              sat;
    } t_res;

endpackage

// ===== rtl/fpa_mul.sv =====
// Pipelined fixed-point multiplier: product, rescale, output register.
module fpa_mul (
    input  logic                        i_clk,
    input  logic [fpa_pkg::WORD_W-1:0]  i_a,
    input  logic [fpa_pkg::WORD_W-1:0]  i_b,
    output logic [fpa_pkg::WORD_W-1:0]  o_res
);
    import fpa_pkg::*;

    logic signed [2*WORD_W-1:0] r_prod;
    logic [WORD_W-1:0]          r_res;
    logic [WORD_W-1:0]          r_out;

    always_ff @(posedge i_clk) begin
        r_prod <= $signed(i_a) * $signed(i_b);
        r_res  <= WORD_W'(r_prod >>> FRACTION_BITS);
        r_out  <= r_res;
    end

    assign o_res = r_out;
endmodule

// ===== rtl/fpa_conv.sv =====
// Float32 <-> fixed conversion, three register stages.
module fpa_conv (
    input  logic                        i_clk,
    input  logic [fpa_pkg::WORD_W-1:0]  i_a,
    input  logic [31:0]                 i_fbits,
    output logic [fpa_pkg::WORD_W-1:0]  o_fix,
    output logic                        o_sat,
    output logic [31:0]                 o_flt
);
    import fpa_pkg::*;

    // stage A
    logic              r_a_fneg, r_a_nan, r_a_inf, r_a_ez;
    logic [23:0]       r_a_m;
    logic signed [9:0] r_a_sh;
    logic              r_a_sgn, r_a_xz;
    logic [WORD_W-1:0] r_a_mag;
    logic [4:0]        r_a_p;
    logic [WORD_W-1:0] n_mag;
    logic [4:0]        n_p;

    // stage B
    logic              r_b_fneg, r_b_nan, r_b_inf, r_b_big, r_b_rnd;
    logic [55:0]       r_b_v;
    logic              r_b_sgn, r_b_xz;
    logic [WORD_W-1:0] r_b_norm;
    logic [4:0]        r_b_p;
    logic              n_big, n_rnd;
    logic [55:0]       n_v;
    logic [9:0]        n_negk;
    logic [4:0]        n_km1;

    // stage C
    logic [WORD_W-1:0] r_fix;
    logic              r_sat;
    logic [31:0]       r_flt;
    logic [55:0]       n_fmag;
    logic [32:0]       n_lim;
    logic [WORD_W-1:0] n_fix;
    logic              n_sat;
    logic [24:0]       n_keep;
    logic [7:0]        n_exp;
    logic [31:0]       n_flt;

    always_comb begin
        n_mag = i_a[WORD_W-1] ? WORD_W'(~i_a + 1'b1) : i_a;
        n_p   = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (n_mag[i]) n_p = 5'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_fneg <= i_fbits[31];
        r_a_nan  <= (i_fbits[30:23] == 8'hFF) && (i_fbits[22:0] != '0);
        r_a_inf  <= (i_fbits[30:23] == 8'hFF) && (i_fbits[22:0] == '0);
        r_a_ez   <= (i_fbits[30:23] == 8'h00);
        r_a_m    <= {1'b1, i_fbits[22:0]};
        r_a_sh   <= $signed(10'({2'b00, i_fbits[30:23]}) - 10'(FLT_BIAS_SH));
        r_a_sgn  <= i_a[WORD_W-1];
        r_a_xz   <= (i_a == '0);
        r_a_mag  <= n_mag;
        r_a_p    <= n_p;
    end

    always_comb begin
        n_big  = 1'b0;
        n_rnd  = 1'b0;
        n_v    = '0;
        n_negk = 10'(-r_a_sh);
        n_km1  = 5'(n_negk - 10'd1);
        if (r_a_ez) begin
            n_v = '0;
        end else if (r_a_sh >= 0) begin
            if (r_a_sh > 10'sd31) n_big = 1'b1;
            else n_v = 56'(r_a_m) << r_a_sh[4:0];
        end else if (n_negk <= 10'd25) begin
            n_v   = 56'(r_a_m >> n_km1);
            n_rnd = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_fneg <= r_a_fneg;
        r_b_nan  <= r_a_nan;
        r_b_inf  <= r_a_inf;
        r_b_big  <= n_big;
        r_b_rnd  <= n_rnd;
        r_b_v    <= n_v;
        r_b_sgn  <= r_a_sgn;
        r_b_xz   <= r_a_xz;
        r_b_norm <= r_a_mag << (5'd31 - r_a_p);
        r_b_p    <= r_a_p;
    end

    always_comb begin
        n_fmag = r_b_rnd ? ((r_b_v + 56'd1) >> 1) : r_b_v;
        n_lim  = r_b_fneg ? 33'h080000000 : 33'h07FFFFFFF;
        n_sat  = 1'b0;
        if (r_b_nan) begin
            n_fix = '0;
            n_sat = 1'b1;
        end else if (r_b_inf || r_b_big || (n_fmag > 56'(n_lim))) begin
            n_fix = r_b_fneg ? 32'h80000000 : 32'h7FFFFFFF;
            n_sat = 1'b1;
        end else begin
            n_fix = r_b_fneg ? WORD_W'(~n_fmag[31:0] + 1'b1) : n_fmag[31:0];
        end

        // round to nearest even on guard / sticky
        n_keep = {1'b0, r_b_norm[31:8]}
               + 25'(r_b_norm[7] & ((|r_b_norm[6:0]) | r_b_norm[8]));
        n_exp  = 8'(r_b_p) + 8'(EXP_OFFSET) + 8'(n_keep[24]);
        if (r_b_xz) n_flt = '0;
        else if (n_keep[24]) n_flt = {r_b_sgn, n_exp, n_keep[23:1]};
        else n_flt = {r_b_sgn, n_exp, n_keep[22:0]};
    end

    always_ff @(posedge i_clk) begin
        r_fix <= n_fix;
        r_sat <= n_sat;
        r_flt <= n_flt;
    end

    assign o_fix = r_fix;
    assign o_sat = r_sat;
    assign o_flt = r_flt;
endmodule

// ===== rtl/fpa_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, truncating.
module fpa_div (
    input  logic                        i_clk,
    input  logic [fpa_pkg::WORD_W-1:0]  i_a,
    input  logic [fpa_pkg::WORD_W-1:0]  i_b,
    output logic [fpa_pkg::WORD_W-1:0]  o_quot
);
    import fpa_pkg::*;

    logic [DIV_STEPS-1:0] r_dvd [0:DIV_STEPS];
    logic [WORD_W-1:0]    r_rem [0:DIV_STEPS];
    logic [WORD_W-1:0]    r_q   [0:DIV_STEPS];
    logic [WORD_W-1:0]    r_dvs [0:DIV_STEPS];
    logic                 r_neg [0:DIV_STEPS];
    logic [WORD_W-1:0]    r_quot;

    logic [DIV_STEPS-1:0] n_dvd [0:DIV_STEPS-1];
    logic [WORD_W-1:0]    n_rem [0:DIV_STEPS-1];
    logic [WORD_W-1:0]    n_q   [0:DIV_STEPS-1];
    logic [WORD_W:0]      n_t   [0:DIV_STEPS-1];
    logic [WORD_W-1:0]    n_maga, n_magb;

    assign n_maga = i_a[WORD_W-1] ? WORD_W'(~i_a + 1'b1) : i_a;
    assign n_magb = i_b[WORD_W-1] ? WORD_W'(~i_b + 1'b1) : i_b;

    always_comb begin
        for (int j = 0; j < DIV_STEPS; j++) begin
            n_t[j]   = {r_rem[j], r_dvd[j][DIV_STEPS-1]};
            n_dvd[j] = r_dvd[j] << 1;
            if (n_t[j] >= {1'b0, r_dvs[j]}) begin
                n_rem[j] = WORD_W'(n_t[j] - {1'b0, r_dvs[j]});
                n_q[j]   = {r_q[j][WORD_W-2:0], 1'b1};
            end else begin
                n_rem[j] = n_t[j][WORD_W-1:0];
                n_q[j]   = {r_q[j][WORD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd[0] <= DIV_STEPS'({n_maga, {FRACTION_BITS{1'b0}}});
        r_rem[0] <= '0;
        r_q[0]   <= '0;
        r_dvs[0] <= n_magb;
        r_neg[0] <= i_a[WORD_W-1] ^ i_b[WORD_W-1];
        for (int j = 0; j < DIV_STEPS; j++) begin
            r_dvd[j+1] <= n_dvd[j];
            r_rem[j+1] <= n_rem[j];
            r_q[j+1]   <= n_q[j];
            r_dvs[j+1] <= r_dvs[j];
            r_neg[j+1] <= r_neg[j];
        end
        r_quot <= r_neg[DIV_STEPS] ? WORD_W'(~r_q[DIV_STEPS] + 1'b1) : r_q[DIV_STEPS];
    end

    assign o_quot = r_quot;
endmodule

// ===== rtl/fixed_point_alu.sv =====
// Q24.8 fixed-point ALU, top level.
// One operation is taken every cycle (busy never rises) and its result shows
// on the o_ ports, marked by o_valid; results come out in issue order and
// must be taken when shown. The latency is set by the divider, a pipeline of
// one quotient bit per stage over 40 bits; all other operations are delayed
// to match it.
module fixed_point_alu (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  i_kind,
    input  logic [31:0] i_operand_a,
    input  logic [31:0] i_operand_b,
    input  logic [31:0] i_float_bits,
    output logic        o_valid,
    output logic [31:0] o_result_word,
    output logic [31:0] o_float_out,
    output logic        o_greater,
    output logic        o_equal,
    output logic        o_less,
    output logic        o_divide_by_zero,
    output logic        o_saturated
);
    import fpa_pkg::*;

    logic              r_s1_vld;
    logic [3:0]        r_s1_kind;
    logic [WORD_W-1:0] r_s1_a, r_s1_b;
    logic [31:0]       r_s1_f;

    logic              r_vld  [0:FAST_LAT-1];
    logic [3:0]        r_kind [0:FAST_LAT-1];
    t_res              r_res  [0:FAST_LAT-1];

    logic              r_dly_vld [0:DLY_STAGES-1];
    logic              r_dly_div [0:DLY_STAGES-1];
    t_res              r_dly_res [0:DLY_STAGES-1];

    t_res              r_out;
    logic              r_out_vld;

    t_res              n_simple, n_merge, n_out;
    logic [WORD_W-1:0] w_mul, w_fix, w_quot;
    logic              w_sat;
    logic [31:0]       w_flt;

    assign busy = 1'b0;

    fpa_mul u_mul (
        .i_clk (i_clk),
        .i_a   (r_s1_a),
        .i_b   (r_s1_b),
        .o_res (w_mul)
    );

    fpa_conv u_conv (
        .i_clk   (i_clk),
        .i_a     (r_s1_a),
        .i_fbits (r_s1_f),
        .o_fix   (w_fix),
        .o_sat   (w_sat),
        .o_flt   (w_flt)
    );

    fpa_div u_div (
        .i_clk  (i_clk),
        .i_a    (r_s1_a),
        .i_b    (r_s1_b),
        .o_quot (w_quot)
    );

    always_comb begin
        n_simple = '0;
        case (r_s1_kind)
            K_ADD:     n_simple.word = r_s1_a + r_s1_b;
            K_SUB:     n_simple.word = r_s1_a - r_s1_b;
            K_DIV:     n_simple.dz   = (r_s1_b == '0);
            K_CMP: begin
                n_simple.gt = $signed(r_s1_a) >  $signed(r_s1_b);
                n_simple.eq = r_s1_a == r_s1_b;
                n_simple.lt = $signed(r_s1_a) <  $signed(r_s1_b);
            end
            K_INT2FIX: n_simple.word = r_s1_a << FRACTION_BITS;
            K_TO_INT:  n_simple.word = WORD_W'($signed(r_s1_a) >>> FRACTION_BITS);
            default:   n_simple = '0;
        endcase
    end

    always_comb begin
        n_merge = r_res[FAST_LAT-1];
        case (r_kind[FAST_LAT-1])
            K_MUL:      n_merge.word = w_mul;
            K_FLT2FIX: begin
                n_merge.word = w_fix;
                n_merge.sat  = w_sat;
            end
            K_TO_FLOAT: n_merge.flt  = w_flt;
            default:    n_merge = r_res[FAST_LAT-1];
        endcase
    end

    always_comb begin
        n_out = r_dly_res[DLY_STAGES-1];
        if (r_dly_div[DLY_STAGES-1] && !r_dly_res[DLY_STAGES-1].dz) n_out.word = w_quot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < FAST_LAT; i++) r_vld[i] <= 1'b0;
            for (int i = 0; i < DLY_STAGES; i++) r_dly_vld[i] <= 1'b0;
        end else begin
            r_s1_vld  <= start;
            r_vld[0]  <= r_s1_vld;
            for (int i = 1; i < FAST_LAT; i++) r_vld[i] <= r_vld[i-1];
            r_dly_vld[0] <= r_vld[FAST_LAT-1];
            for (int i = 1; i < DLY_STAGES; i++) r_dly_vld[i] <= r_dly_vld[i-1];
            r_out_vld <= r_dly_vld[DLY_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_kind <= i_kind;
        r_s1_a    <= i_operand_a;
        r_s1_b    <= i_operand_b;
        r_s1_f    <= i_float_bits;
        r_kind[0] <= r_s1_kind;
        r_res[0]  <= n_simple;
        for (int i = 1; i < FAST_LAT; i++) begin
            r_kind[i] <= r_kind[i-1];
            r_res[i]  <= r_res[i-1];
        end
        r_dly_res[0] <= n_merge;
        r_dly_div[0] <= (r_kind[FAST_LAT-1] == K_DIV);
        for (int i = 1; i < DLY_STAGES; i++) begin
            r_dly_res[i] <= r_dly_res[i-1];
            r_dly_div[i] <= r_dly_div[i-1];
        end
        r_out <= n_out;
    end

    assign o_valid          = r_out_vld;
    assign o_result_word    = r_out.word;
    assign o_float_out      = r_out.flt;
    assign o_greater        = r_out.gt;
    assign o_equal          = r_out.eq;
    assign o_less           = r_out.lt;
    assign o_divide_by_zero = r_out.dz;
    assign o_saturated      = r_out.sat;
endmodule
